// ----- rtl/pcle_pkg.sv -----
// pcle_pkg: shared types, constants and helpers of the pooled cursor list engine
`default_nettype none
package pcle_pkg;

	// pool sizes
	localparam int NODE_COUNT = 64;
	localparam int NUM_HEADS  = 8;

	// widths
	localparam int PW  = 7;
	localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int LTW = 5;
	localparam int LIW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
	localparam int CW  = 7;

	localparam logic [PW-1:0]  NIL  = {PW{1'b1}};
	localparam logic [LTW-1:0] LNIL = {LTW{1'b1}};

	// operation codes
	localparam logic [3:0] MODE_CREATE  = 4'd0;
	localparam logic [3:0] MODE_COUNT   = 4'd1;
	localparam logic [3:0] MODE_CURRENT = 4'd2;
	localparam logic [3:0] MODE_FIRST   = 4'd3;
	localparam logic [3:0] MODE_LAST    = 4'd4;
	localparam logic [3:0] MODE_NEXT    = 4'd5;
	localparam logic [3:0] MODE_PREV    = 4'd6;
	localparam logic [3:0] MODE_ADD     = 4'd7;
	localparam logic [3:0] MODE_INSERT  = 4'd8;
	localparam logic [3:0] MODE_APPEND  = 4'd9;
	localparam logic [3:0] MODE_PREPEND = 4'd10;
	localparam logic [3:0] MODE_CONCAT  = 4'd11;
	localparam logic [3:0] MODE_FREE    = 4'd12;
	localparam logic [3:0] MODE_TRIM    = 4'd13;
	localparam logic [3:0] MODE_REMOVE  = 4'd14;
	localparam logic [3:0] MODE_MAX     = 4'd14;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_POOL  = 2'd2;
	localparam logic [1:0] ST_NOLST = 2'd3;

	// cursor states
	localparam logic [1:0] CUR_EMPTY = 2'd0;
	localparam logic [1:0] CUR_START = 2'd1;
	localparam logic [1:0] CUR_END   = 2'd2;
	localparam logic [1:0] CUR_ON    = 2'd3;

	typedef struct packed {
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
		logic [PW-1:0] cur;
		logic [1:0]    cst;
		logic [CW-1:0] cnt;
		logic          alloc;
	} head_t;

	localparam head_t HEAD_CLR = '{head: NIL, tail: NIL, cur: NIL, cst: CUR_EMPTY,
		cnt: '0, alloc: 1'b0};

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_l;
		logic load_m;
		logic exec;
		logic s2;
		logic s3;
		logic walk;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic to_walk;
	} sts_t;

	function automatic logic is_nil(input logic [PW-1:0] p);
		return {1'b0, p} >= (PW+1)'(NODE_COUNT);
	endfunction

	function automatic logic is_on(input head_t h);
		return (h.cst == CUR_ON) && !is_nil(h.cur);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pcle_ctrl.sv -----
// pcle_ctrl: sequencing state machine of the pooled cursor list engine
`default_nettype none
module pcle_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  pcle_pkg::sts_t  sts,
	output pcle_pkg::cmd_t  cmd,
	output logic            busy
);
	import pcle_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOADL = 3'd1;
	localparam logic [2:0] S_LOADM = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_STEP2 = 3'd4;
	localparam logic [2:0] S_STEP3 = 3'd5;
	localparam logic [2:0] S_WALK  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_LOADL;
			S_LOADL: state_d = S_LOADM;
			S_LOADM: state_d = S_EXEC;
			S_EXEC: begin
				if (sts.done) state_d = S_IDLE;
				else if (sts.to_walk) state_d = S_WALK;
				else state_d = S_STEP2;
			end
			S_STEP2: state_d = sts.done ? S_IDLE : S_STEP3;
			S_STEP3: state_d = S_IDLE;
			S_WALK:  if (sts.done) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// commands
	always_comb begin
		cmd.accept = (state_q == S_IDLE) && start;
		cmd.load_l = (state_q == S_LOADL);
		cmd.load_m = (state_q == S_LOADM);
		cmd.exec   = (state_q == S_EXEC);
		cmd.s2     = (state_q == S_STEP2);
		cmd.s3     = (state_q == S_STEP3);
		cmd.walk   = (state_q == S_WALK);
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/pcle_datapath.sv -----
// pcle_datapath: node memories, head table, free stacks and result register
`default_nettype none
module pcle_datapath (
	input  wire             clk,
	input  wire             arst_n,
	input  pcle_pkg::cmd_t  cmd,
	output pcle_pkg::sts_t  sts,
	input  wire [3:0]       mode,
	input  wire [2:0]       list_id,
	input  wire [2:0]       other_list_id,
	input  wire [31:0]      item,
	output logic            strobe,
	output logic [1:0]      status,
	output logic [31:0]     item_out,
	output logic            item_valid,
	output logic [2:0]      new_list_id,
	output logic [6:0]      item_count,
	output logic            last
);
	import pcle_pkg::*;

	// latched beat
	logic [3:0]  mode_q;
	logic [2:0]  lid_q;
	logic [2:0]  oid_q;
	logic [31:0] itm_in_q;

	// working registers
	head_t         l_q, l_d, m_q;
	logic [PW-1:0] n_q, n_d;
	logic [CW-1:0] k_q, k_d;
	logic          step_q, step_d;
	logic          nbn_en_q, nbn_en_d, nbp_en_q, nbp_en_d;
	logic [PW-1:0] nbn_a_q, nbn_a_d, nbp_a_q, nbp_a_d;

	// pools
	logic [PW-1:0]  nf_top_q, nf_top_d;
	logic [LTW-1:0] lf_top_q, lf_top_d;
	logic [LTW-1:0] lf_link_q [NUM_HEADS];
	head_t          ht_q [NUM_HEADS];

	// node memories
	logic [PW-1:0] nxt_mem_q [NODE_COUNT];
	logic [PW-1:0] prv_mem_q [NODE_COUNT];
	logic [31:0]   itm_mem_q [NODE_COUNT];
	logic [PW-1:0] flk_mem_q [NODE_COUNT];
	logic          flk_vld_q [NODE_COUNT];
	logic [PW-1:0] rd_nxt_q, rd_prv_q, flk_rd_q, flk_init_q;
	logic [31:0]   rd_itm_q;
	logic          flk_vrd_q;

	logic [PW-1:0] rd_addr;
	logic          nxt_we, prv_we, itm_we, flk_we;
	logic [PW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, itm_wa, flk_wa, flk_wd;
	logic [31:0]   itm_wd;

	logic           ht_we, cr_we, rel_we;
	logic [LTW-1:0] rel_id;

	// result
	logic          emit, e_last, e_iv;
	logic [1:0]    e_st;
	logic [31:0]   e_item;
	logic [2:0]    e_nid;
	logic [CW-1:0] e_cnt;
	logic          strobe_q, item_valid_q, last_q;
	logic [1:0]    status_q;
	logic [31:0]   item_out_q;
	logic [2:0]    new_list_id_q;
	logic [CW-1:0] item_count_q;

	logic [LTW-1:0] lid_x, oid_x, ht_ra;
	logic           list_ok, oth_ok, fwd, grp_add, front;
	logic [PW-1:0]  nn, fdat, own_nxt, own_prv;
	head_t          ht_rd;

	assign lid_x   = {2'b00, lid_q};
	assign oid_x   = {2'b00, oid_q};
	assign ht_ra   = cmd.load_m ? oid_x : lid_x;
	assign ht_rd   = ht_q[ht_ra[LIW-1:0]];
	assign list_ok = (lid_x < LTW'(NUM_HEADS)) && l_q.alloc;
	assign oth_ok  = (oid_x < LTW'(NUM_HEADS)) && m_q.alloc;
	assign fwd     = (mode_q == MODE_NEXT);
	assign grp_add = (mode_q == MODE_ADD) || (mode_q == MODE_INSERT) ||
		(mode_q == MODE_APPEND) || (mode_q == MODE_PREPEND);
	assign fdat    = flk_vrd_q ? flk_rd_q : flk_init_q;
	assign nn      = fwd ? rd_nxt_q : rd_prv_q;
	assign front   = (mode_q == MODE_PREPEND) || ((mode_q != MODE_APPEND) &&
		((l_q.cst == CUR_START) || ((mode_q == MODE_INSERT) && (l_q.cst != CUR_END))));

	// operation logic
	always_comb begin
		l_d = l_q; n_d = n_q; k_d = k_q; step_d = step_q;
		nbn_en_d = nbn_en_q; nbn_a_d = nbn_a_q; nbp_en_d = nbp_en_q; nbp_a_d = nbp_a_q;
		nf_top_d = nf_top_q; lf_top_d = lf_top_q;
		rd_addr = n_q;
		nxt_we = 1'b0; nxt_wa = n_q; nxt_wd = NIL;
		prv_we = 1'b0; prv_wa = n_q; prv_wd = NIL;
		itm_we = 1'b0; itm_wa = n_q; itm_wd = itm_in_q;
		flk_we = 1'b0; flk_wa = n_q; flk_wd = nf_top_q;
		cr_we = 1'b0; rel_we = 1'b0; rel_id = lid_x;
		own_nxt = NIL; own_prv = NIL;
		emit = 1'b0; e_last = 1'b1; e_iv = 1'b0; e_st = ST_OK; e_item = '0;
		e_nid = '0; e_cnt = '0;
		sts.done = 1'b0; sts.to_walk = 1'b0;

		if (cmd.exec) begin
			if (mode_q == MODE_CREATE) begin
				emit = 1'b1; sts.done = 1'b1;
				if (lf_top_q >= LTW'(NUM_HEADS)) begin
					e_st = ST_POOL;
				end else begin
					cr_we = 1'b1;
					lf_top_d = lf_link_q[lf_top_q[LIW-1:0]];
					e_nid = lf_top_q[2:0];
				end
			end else if (mode_q > MODE_MAX) begin
				emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
			end else if (!list_ok) begin
				emit = 1'b1; sts.done = 1'b1; e_st = ST_NOLST;
			end else begin
				case (mode_q)
					MODE_COUNT: begin
						emit = 1'b1; sts.done = 1'b1;
					end
					MODE_CURRENT: begin
						if (is_on(l_q)) rd_addr = l_q.cur;
						else begin emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE; end
					end
					MODE_FIRST, MODE_LAST: begin
						if (l_q.cnt == '0) begin
							l_d.cst = CUR_EMPTY; l_d.cur = NIL;
							emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
						end else begin
							l_d.cur = (mode_q == MODE_FIRST) ? l_q.head : l_q.tail;
							l_d.cst = CUR_ON;
							rd_addr = l_d.cur;
						end
					end
					MODE_NEXT, MODE_PREV: begin
						step_d = 1'b0;
						if (l_q.cnt == '0) begin
							emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
						end else if (is_on(l_q)) begin
							rd_addr = l_q.cur; step_d = 1'b1;
						end else if (l_q.cst == (fwd ? CUR_END : CUR_START)) begin
							emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
						end else begin
							l_d.cur = fwd ? l_q.head : l_q.tail;
							l_d.cst = CUR_ON;
							rd_addr = l_d.cur;
						end
					end
					MODE_ADD, MODE_INSERT, MODE_APPEND, MODE_PREPEND: begin
						if (is_nil(nf_top_q)) begin
							emit = 1'b1; sts.done = 1'b1; e_st = ST_POOL;
						end else begin
							n_d = nf_top_q; rd_addr = l_q.cur;
						end
					end
					MODE_CONCAT: begin
						emit = 1'b1; sts.done = 1'b1;
						if (!oth_ok) e_st = ST_NOLST;
						else if (oid_q == lid_q) e_st = ST_RANGE;
						else begin
							if (m_q.cnt != '0) begin
								if (l_q.cnt == '0) begin
									l_d.head = m_q.head; l_d.tail = m_q.tail;
								end else begin
									nxt_we = 1'b1; nxt_wa = l_q.tail; nxt_wd = m_q.head;
									prv_we = 1'b1; prv_wa = m_q.head; prv_wd = l_q.tail;
									l_d.tail = m_q.tail;
								end
								l_d.cnt = l_q.cnt + m_q.cnt;
							end
							rel_we = 1'b1; rel_id = oid_x;
						end
					end
					MODE_FREE: begin
						if (is_nil(l_q.head)) begin
							rel_we = 1'b1;
							emit = 1'b1; sts.done = 1'b1;
						end else begin
							n_d = l_q.head; rd_addr = l_q.head; k_d = '0;
							sts.to_walk = 1'b1;
						end
					end
					MODE_TRIM: begin
						if (l_q.cnt == '0 || is_nil(l_q.tail)) begin
							emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
						end else begin
							n_d = l_q.tail; rd_addr = l_q.tail;
						end
					end
					MODE_REMOVE: begin
						if (l_q.cnt == '0 || !is_on(l_q)) begin
							emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
						end else begin
							n_d = l_q.cur; rd_addr = l_q.cur;
						end
					end
					default: begin
						emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
					end
				endcase
				e_cnt = l_d.cnt;
			end
		end else if (cmd.s2) begin
			case (mode_q)
				MODE_CURRENT, MODE_FIRST, MODE_LAST: begin
					emit = 1'b1; sts.done = 1'b1; e_iv = 1'b1; e_item = rd_itm_q;
				end
				MODE_NEXT, MODE_PREV: begin
					if (!step_q) begin
						emit = 1'b1; sts.done = 1'b1; e_iv = 1'b1; e_item = rd_itm_q;
					end else if (is_nil(nn)) begin
						l_d.cur = NIL; l_d.cst = fwd ? CUR_END : CUR_START;
						emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
					end else begin
						l_d.cur = nn; rd_addr = nn;
					end
				end
				MODE_ADD, MODE_INSERT, MODE_APPEND, MODE_PREPEND: begin
					nf_top_d = fdat;
					nbn_en_d = 1'b0; nbp_en_d = 1'b0;
					nbn_a_d = l_q.cur; nbp_a_d = l_q.cur;
					if (l_q.cnt == '0) begin
						l_d.head = n_q; l_d.tail = n_q;
					end else if (mode_q == MODE_APPEND || mode_q == MODE_PREPEND ||
							!is_on(l_q)) begin
						if (front) begin
							own_nxt = l_q.head;
							nbp_en_d = !is_nil(l_q.head); nbp_a_d = l_q.head;
							l_d.head = n_q;
							if (is_nil(l_q.tail)) l_d.tail = n_q;
						end else begin
							own_prv = l_q.tail;
							nbn_en_d = !is_nil(l_q.tail); nbn_a_d = l_q.tail;
							l_d.tail = n_q;
							if (is_nil(l_q.head)) l_d.head = n_q;
						end
					end else if (mode_q == MODE_ADD) begin
						own_nxt = rd_nxt_q; own_prv = l_q.cur;
						nbn_en_d = 1'b1;
						if (!is_nil(rd_nxt_q)) begin
							nbp_en_d = 1'b1; nbp_a_d = rd_nxt_q;
						end else l_d.tail = n_q;
					end else begin
						own_nxt = l_q.cur; own_prv = rd_prv_q;
						nbp_en_d = 1'b1;
						if (!is_nil(rd_prv_q)) begin
							nbn_en_d = 1'b1; nbn_a_d = rd_prv_q;
						end else l_d.head = n_q;
					end
					l_d.cur = n_q; l_d.cst = CUR_ON; l_d.cnt = l_q.cnt + 1'b1;
					itm_we = 1'b1;
					nxt_we = 1'b1; nxt_wd = own_nxt;
					prv_we = 1'b1; prv_wd = own_prv;
				end
				MODE_TRIM: begin
					if (!is_nil(rd_prv_q)) begin
						nxt_we = 1'b1; nxt_wa = rd_prv_q; nxt_wd = NIL;
						l_d.tail = rd_prv_q; l_d.cur = rd_prv_q; l_d.cst = CUR_ON;
						l_d.cnt = l_q.cnt - 1'b1;
					end else begin
						l_d = HEAD_CLR; l_d.alloc = l_q.alloc;
					end
					flk_we = 1'b1; nf_top_d = n_q;
					emit = 1'b1; sts.done = 1'b1; e_iv = 1'b1; e_item = rd_itm_q;
				end
				MODE_REMOVE: begin
					if (!is_nil(rd_prv_q)) begin
						nxt_we = 1'b1; nxt_wa = rd_prv_q; nxt_wd = rd_nxt_q;
					end else l_d.head = rd_nxt_q;
					if (!is_nil(rd_nxt_q)) begin
						prv_we = 1'b1; prv_wa = rd_nxt_q; prv_wd = rd_prv_q;
						l_d.cur = rd_nxt_q; l_d.cst = CUR_ON;
					end else begin
						l_d.tail = rd_prv_q; l_d.cur = NIL; l_d.cst = CUR_END;
					end
					l_d.cnt = l_q.cnt - 1'b1;
					flk_we = 1'b1; nf_top_d = n_q;
					emit = 1'b1; sts.done = 1'b1; e_iv = 1'b1; e_item = rd_itm_q;
				end
				default: begin
					emit = 1'b1; sts.done = 1'b1; e_st = ST_RANGE;
				end
			endcase
			e_cnt = l_d.cnt;
		end else if (cmd.s3) begin
			// neighbour links of a new node, or the item after a step
			if (grp_add) begin
				nxt_we = nbn_en_q; nxt_wa = nbn_a_q; nxt_wd = n_q;
				prv_we = nbp_en_q; prv_wa = nbp_a_q; prv_wd = n_q;
			end else begin
				e_iv = 1'b1; e_item = rd_itm_q;
			end
			emit = 1'b1; sts.done = 1'b1; e_cnt = l_q.cnt;
		end else if (cmd.walk) begin
			// one node a cycle: emit, return to pool, fetch the next
			e_last = is_nil(rd_nxt_q) || ({1'b0, k_q} + 1'b1 >= (CW+1)'(NODE_COUNT));
			emit = 1'b1; e_iv = 1'b1; e_item = rd_itm_q;
			flk_we = 1'b1; nf_top_d = n_q;
			n_d = rd_nxt_q; rd_addr = rd_nxt_q; k_d = k_q + 1'b1;
			if (e_last) begin
				rel_we = 1'b1; sts.done = 1'b1;
			end
		end
	end

	assign ht_we = (cmd.exec || cmd.s2 || cmd.s3) && list_ok && (mode_q != MODE_CREATE) &&
		(mode_q != MODE_FREE) && (mode_q <= MODE_MAX);

	// beat latch and working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode; lid_q <= list_id; oid_q <= other_list_id; itm_in_q <= item;
		end
		if (cmd.load_l) l_q <= ht_rd;
		else l_q <= l_d;
		if (cmd.load_m) m_q <= ht_rd;
		n_q <= n_d; k_q <= k_d; step_q <= step_d;
		nbn_en_q <= nbn_en_d; nbn_a_q <= nbn_a_d;
		nbp_en_q <= nbp_en_d; nbp_a_q <= nbp_a_d;
	end

	// head table and free stacks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_top_q <= PW'(NODE_COUNT - 1);
			lf_top_q <= LTW'(NUM_HEADS - 1);
			for (int i = 0; i < NUM_HEADS; i++) begin
				ht_q[i] <= HEAD_CLR;
				lf_link_q[i] <= (i == 0) ? LNIL : LTW'(i - 1);
			end
		end else begin
			nf_top_q <= nf_top_d;
			lf_top_q <= rel_we ? rel_id : lf_top_d;
			for (int i = 0; i < NUM_HEADS; i++) begin
				if (rel_we && rel_id == LTW'(i)) begin
					ht_q[i] <= HEAD_CLR;
					lf_link_q[i] <= lf_top_q;
				end else if (ht_we && lid_x == LTW'(i)) begin
					ht_q[i] <= l_d;
				end else if (cr_we && lf_top_q == LTW'(i)) begin
					ht_q[i] <= HEAD_CLR;
					ht_q[i].alloc <= 1'b1;
				end
			end
		end
	end

	// free link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) flk_vld_q[i] <= 1'b0;
		end else if (flk_we) begin
			flk_vld_q[flk_wa[NIW-1:0]] <= 1'b1;
		end
	end

	// node memories, registered reads
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem_q[nxt_wa[NIW-1:0]] <= nxt_wd;
		if (prv_we) prv_mem_q[prv_wa[NIW-1:0]] <= prv_wd;
		if (itm_we) itm_mem_q[itm_wa[NIW-1:0]] <= itm_wd;
		if (flk_we) flk_mem_q[flk_wa[NIW-1:0]] <= flk_wd;
		rd_nxt_q   <= nxt_mem_q[rd_addr[NIW-1:0]];
		rd_prv_q   <= prv_mem_q[rd_addr[NIW-1:0]];
		rd_itm_q   <= itm_mem_q[rd_addr[NIW-1:0]];
		flk_rd_q   <= flk_mem_q[nf_top_q[NIW-1:0]];
		flk_vrd_q  <= flk_vld_q[nf_top_q[NIW-1:0]];
		flk_init_q <= (nf_top_q == '0) ? NIL : nf_top_q - 1'b1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else strobe_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= e_st; item_out_q <= e_item; item_valid_q <= e_iv;
			new_list_id_q <= e_nid; item_count_q <= e_cnt; last_q <= e_last;
		end
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign item_out    = item_out_q;
	assign item_valid  = item_valid_q;
	assign new_list_id = new_list_id_q;
	assign item_count  = item_count_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ----- rtl/pooled_cursor_list_engine.sv -----
// pooled_cursor_list_engine: top level of the pooled cursor list engine
// An operation is taken when start is high and busy is low. Each result is shown for one
// cycle with strobe high and cannot be held off. Operations that touch no node, or end
// early on a status, pass through latch, two head reads and execute; current, first,
// last, trim and remove that return an item go on to a second step, next/prev do too
// and add a third when stepping from a node, and add/insert/append/prepend take all
// three steps, set by the registered node memory reads and the single write port of
// each link memory. Free walks the list at one node a cycle. No clearing pass is needed
// after reset.
`default_nettype none
module pooled_cursor_list_engine (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire [3:0]  mode,
	input  wire [2:0]  list_id,
	input  wire [2:0]  other_list_id,
	input  wire [31:0] item,
	output logic       strobe,
	output logic [1:0] status,
	output logic [31:0] item_out,
	output logic       item_valid,
	output logic [2:0] new_list_id,
	output logic [6:0] item_count,
	output logic       last
);
	import pcle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pcle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pcle_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.list_id       (list_id),
		.other_list_id (other_list_id),
		.item          (item),
		.strobe        (strobe),
		.status        (status),
		.item_out      (item_out),
		.item_valid    (item_valid),
		.new_list_id   (new_list_id),
		.item_count    (item_count),
		.last          (last)
	);

endmodule
`default_nettype wire

// ----- test/pooled_cursor_list_engine_tb.sv -----
// self-checking testbench for the pooled cursor list engine
`default_nettype none
module pooled_cursor_list_engine_tb;
	import pcle_pkg::*;

	typedef struct {
		logic [3:0]  mode;
		logic [2:0]  lid;
		logic [2:0]  oid;
		logic [31:0] item;
	} op_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] item_out;
		logic        item_valid;
		logic [2:0]  new_list_id;
		logic [6:0]  item_count;
		logic        last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [3:0]  mode = '0;
	logic [2:0]  list_id = '0;
	logic [2:0]  other_list_id = '0;
	logic [31:0] item = '0;
	wire         busy, strobe, item_valid, last;
	wire [1:0]   status;
	wire [31:0]  item_out;
	wire [2:0]   new_list_id;
	wire [6:0]   item_count;

	op_t   op_q[$];
	beat_t beat_q[$];
	int    errors = 0;
	int    issued = 0;
	int    quiet = 0;

	// shadow copy of the pools and heads, node arrays indexed by the full link width
	logic [31:0]    m_item[2**PW];
	logic [PW-1:0]  m_next[2**PW];
	logic [PW-1:0]  m_prev[2**PW];
	logic [PW-1:0]  m_nfree[2**PW];
	logic [PW-1:0]  m_nfree_top;
	head_t          m_head[NUM_HEADS];
	logic [LTW-1:0] m_lfree[NUM_HEADS];
	logic [LTW-1:0] m_lfree_top;

	pooled_cursor_list_engine u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.list_id(list_id), .other_list_id(other_list_id), .item(item), .strobe(strobe),
		.status(status), .item_out(item_out), .item_valid(item_valid),
		.new_list_id(new_list_id), .item_count(item_count), .last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic off_pool(input logic [PW-1:0] p);
		return p >= NODE_COUNT;
	endfunction

	task automatic want(input logic [1:0] st, input logic [31:0] it, input logic v,
			input logic [2:0] nid, input logic [6:0] cnt, input logic lst);
		beat_t b;
		b.status = st; b.item_out = it; b.item_valid = v;
		b.new_list_id = nid; b.item_count = cnt; b.last = lst;
		beat_q.push_back(b);
	endtask

	task automatic model_reset();
		for (int i = 0; i < 2**PW; i++) begin
			m_item[i] = '0; m_next[i] = NIL; m_prev[i] = NIL;
			m_nfree[i] = (i == 0 || i >= NODE_COUNT) ? NIL : PW'(i - 1);
		end
		m_nfree_top = PW'(NODE_COUNT - 1);
		for (int i = 0; i < NUM_HEADS; i++) begin
			m_head[i] = HEAD_CLR;
			m_lfree[i] = (i == 0) ? LNIL : LTW'(i - 1);
		end
		m_lfree_top = LTW'(NUM_HEADS - 1);
	endtask

	task automatic node_back(input logic [PW-1:0] n);
		m_next[n] = NIL; m_prev[n] = NIL;
		m_nfree[n] = m_nfree_top;
		m_nfree_top = n;
	endtask

	task automatic head_back(input logic [2:0] id);
		m_head[id] = HEAD_CLR;
		m_lfree[id] = m_lfree_top;
		m_lfree_top = LTW'(id);
	endtask

	task automatic link_front(inout head_t h, input logic [PW-1:0] n);
		m_next[n] = h.head;
		if (!off_pool(h.head)) m_prev[h.head] = n;
		h.head = n;
		if (off_pool(h.tail)) h.tail = n;
	endtask

	task automatic link_back(inout head_t h, input logic [PW-1:0] n);
		m_prev[n] = h.tail;
		if (!off_pool(h.tail)) m_next[h.tail] = n;
		h.tail = n;
		if (off_pool(h.head)) h.head = n;
	endtask

	// expected beats of one operation, updating the shadow state
	task automatic list_predict(input op_t o);
		head_t h, g;
		logic [PW-1:0] n, p, q, nx;
		logic [1:0] st;
		logic [31:0] res;
		logic v, fwd;
		logic [2:0] id;
		int k;
		st = ST_OK; res = '0; v = 1'b0;
		if (o.mode == MODE_CREATE) begin
			if (m_lfree_top >= NUM_HEADS) begin
				want(ST_POOL, '0, 1'b0, '0, '0, 1'b1);
			end else begin
				id = m_lfree_top[2:0];
				m_lfree_top = m_lfree[id];
				m_lfree[id] = LNIL;
				m_head[id] = HEAD_CLR;
				m_head[id].alloc = 1'b1;
				want(ST_OK, '0, 1'b0, id, '0, 1'b1);
			end
			return;
		end
		if (o.mode > MODE_MAX) begin
			want(ST_RANGE, '0, 1'b0, '0, '0, 1'b1);
			return;
		end
		if (!m_head[o.lid].alloc) begin
			want(ST_NOLST, '0, 1'b0, '0, '0, 1'b1);
			return;
		end
		h = m_head[o.lid];
		fwd = (o.mode == MODE_NEXT);
		case (o.mode)
			MODE_COUNT: begin
			end
			MODE_CURRENT: begin
				if (h.cst == CUR_ON && !off_pool(h.cur)) begin
					res = m_item[h.cur]; v = 1'b1;
				end else st = ST_RANGE;
			end
			MODE_FIRST, MODE_LAST: begin
				if (h.cnt == 0) begin
					h.cst = CUR_EMPTY; h.cur = NIL; st = ST_RANGE;
				end else begin
					h.cur = (o.mode == MODE_FIRST) ? h.head : h.tail;
					h.cst = CUR_ON;
					res = m_item[h.cur]; v = 1'b1;
				end
			end
			MODE_NEXT, MODE_PREV: begin
				if (h.cnt == 0) begin
					st = ST_RANGE;
				end else if (h.cst == CUR_ON && !off_pool(h.cur)) begin
					n = fwd ? m_next[h.cur] : m_prev[h.cur];
					if (off_pool(n)) begin
						h.cur = NIL; h.cst = fwd ? CUR_END : CUR_START; st = ST_RANGE;
					end else begin
						h.cur = n; res = m_item[n]; v = 1'b1;
					end
				end else if (h.cst == (fwd ? CUR_END : CUR_START)) begin
					st = ST_RANGE;
				end else begin
					h.cur = fwd ? h.head : h.tail;
					h.cst = CUR_ON;
					res = m_item[h.cur]; v = 1'b1;
				end
			end
			MODE_ADD, MODE_INSERT, MODE_APPEND, MODE_PREPEND: begin
				if (off_pool(m_nfree_top)) begin
					st = ST_POOL;
				end else begin
					n = m_nfree_top;
					m_nfree_top = m_nfree[n];
					m_nfree[n] = NIL; m_next[n] = NIL; m_prev[n] = NIL;
					m_item[n] = o.item;
					if (h.cnt == 0) begin
						h.head = n; h.tail = n;
					end else if (o.mode == MODE_APPEND) link_back(h, n);
					else if (o.mode == MODE_PREPEND) link_front(h, n);
					else if (!(h.cst == CUR_ON && !off_pool(h.cur))) begin
						if (h.cst == CUR_START || (o.mode == MODE_INSERT && h.cst != CUR_END))
							link_front(h, n);
						else
							link_back(h, n);
					end else if (o.mode == MODE_ADD) begin
						q = m_next[h.cur];
						m_next[n] = q;
						if (!off_pool(q)) m_prev[q] = n; else h.tail = n;
						m_prev[n] = h.cur;
						m_next[h.cur] = n;
					end else begin
						p = m_prev[h.cur];
						m_prev[n] = p;
						if (!off_pool(p)) m_next[p] = n; else h.head = n;
						m_next[n] = h.cur;
						m_prev[h.cur] = n;
					end
					h.cur = n; h.cst = CUR_ON;
					h.cnt = h.cnt + 7'd1;
				end
			end
			MODE_CONCAT: begin
				if (!m_head[o.oid].alloc) st = ST_NOLST;
				else if (o.oid == o.lid) st = ST_RANGE;
				else begin
					g = m_head[o.oid];
					if (g.cnt != 0) begin
						if (h.cnt == 0) begin
							h.head = g.head; h.tail = g.tail;
						end else begin
							m_next[h.tail] = g.head;
							m_prev[g.head] = h.tail;
							h.tail = g.tail;
						end
						h.cnt = h.cnt + g.cnt;
					end
					head_back(o.oid);
				end
			end
			MODE_FREE: begin
				n = h.head;
				k = 0;
				for (int guard = 0; guard < NODE_COUNT && !off_pool(n); guard++) begin
					nx = m_next[n];
					want(ST_OK, m_item[n], 1'b1, '0, '0, off_pool(nx) || guard + 1 >= NODE_COUNT);
					node_back(n);
					k++;
					n = nx;
				end
				head_back(o.lid);
				if (k == 0) want(ST_OK, '0, 1'b0, '0, '0, 1'b1);
				return;
			end
			MODE_TRIM: begin
				if (h.cnt == 0 || off_pool(h.tail)) begin
					st = ST_RANGE;
				end else begin
					n = h.tail;
					p = m_prev[n];
					if (!off_pool(p)) begin
						m_next[p] = NIL; h.tail = p; h.cur = p; h.cst = CUR_ON;
					end else begin
						h = HEAD_CLR; h.alloc = 1'b1; h.cnt = 7'd1;
					end
					h.cnt = h.cnt - 7'd1;
					res = m_item[n]; v = 1'b1;
					node_back(n);
				end
			end
			MODE_REMOVE: begin
				if (h.cnt == 0 || !(h.cst == CUR_ON && !off_pool(h.cur))) begin
					st = ST_RANGE;
				end else begin
					n = h.cur;
					p = m_prev[n];
					q = m_next[n];
					if (!off_pool(p)) m_next[p] = q; else h.head = q;
					if (!off_pool(q)) begin
						m_prev[q] = p; h.cur = q; h.cst = CUR_ON;
					end else begin
						h.tail = p; h.cur = NIL; h.cst = CUR_END;
					end
					h.cnt = h.cnt - 7'd1;
					res = m_item[n]; v = 1'b1;
					node_back(n);
				end
			end
			default: st = ST_RANGE;
		endcase
		m_head[o.lid] = h;
		want(st, res, v, '0, h.alloc ? h.cnt : '0, 1'b1);
	endtask

	task automatic queue_op(input logic [3:0] m, input logic [2:0] l, input logic [2:0] o,
			input logic [31:0] it);
		op_t x;
		x.mode = m; x.lid = l; x.oid = o; x.item = it;
		op_q.push_back(x);
		list_predict(x);
	endtask

	function automatic logic [31:0] rand_item();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// an allocated list most of the time, otherwise any id
	function automatic logic [2:0] pick_list();
		logic [2:0] l;
		for (int t = 0; t < 16; t++) begin
			l = 3'($urandom_range(NUM_HEADS - 1));
			if (m_head[l].alloc) return l;
		end
		return 3'($urandom_range(NUM_HEADS - 1));
	endfunction

	task automatic random_op();
		int r;
		logic [2:0] l;
		r = $urandom_range(99);
		l = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : pick_list();
		if (r < 3) queue_op(4'($urandom_range(15)), 3'($urandom), 3'($urandom), $urandom);
		else if (r < 10) queue_op(MODE_CREATE, 3'($urandom), 3'($urandom), $urandom);
		else if (r < 15) queue_op(MODE_FREE, l, 3'($urandom), $urandom);
		else if (r < 21) queue_op(MODE_CONCAT, l, pick_list(), $urandom);
		else if (r < 48) queue_op(4'($urandom_range(MODE_PREPEND, MODE_ADD)), l, 3'($urandom),
			rand_item());
		else if (r < 60) queue_op(4'($urandom_range(MODE_REMOVE, MODE_TRIM)), l, 3'($urandom),
			$urandom);
		else queue_op(4'($urandom_range(MODE_PREV, MODE_COUNT)), l, 3'($urandom), $urandom);
	endtask

	// driver: next operation after each accepted beat, with random gaps
	always @(posedge clk) begin
		logic gap;
		op_t x;
		if (!arst_n) begin
			start <= 1'b0;
		end else if ((start && !busy) || !start) begin
			gap = !(issued >= 40 && issued < 100) && ($urandom_range(99) < 23);
			if (op_q.size() > 0 && !gap) begin
				x = op_q.pop_front();
				start <= 1'b1;
				mode <= x.mode;
				list_id <= x.lid;
				other_list_id <= x.oid;
				item <= x.item;
				issued <= issued + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: each result beat against the oldest expectation
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && strobe) begin
			if (beat_q.size() == 0) begin
				$display("%0t: unexpected beat status %0d item %h", $time, status, item_out);
				errors <= errors + 1;
			end else begin
				e = beat_q.pop_front();
				if (status !== e.status || item_out !== e.item_out ||
						item_valid !== e.item_valid || new_list_id !== e.new_list_id ||
						item_count !== e.item_count || last !== e.last) begin
					$display("%0t: mismatch expected st %0d it %h v %0d id %0d cnt %0d last %0d",
						$time, e.status, e.item_out, e.item_valid, e.new_list_id,
						e.item_count, e.last);
					$display("%0t:          actual   st %0d it %h v %0d id %0d cnt %0d last %0d",
						$time, status, item_out, item_valid, new_list_id, item_count, last);
					errors <= errors + 1;
				end
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet <= 0;
		end else if (quiet >= 5000) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [2:0] l;
		model_reset();
		// directed: heads, empty-list cases, cursor edges, concat and free corners
		queue_op(MODE_COUNT, 3'd0, 3'd0, '0);
		for (int i = 0; i < NUM_HEADS + 1; i++) queue_op(MODE_CREATE, 3'd7, 3'd7, '1);
		queue_op(MODE_MAX + 4'd1, 3'd7, 3'd7, '1);
		queue_op(MODE_FIRST, 3'd7, 3'd0, '0);
		queue_op(MODE_NEXT, 3'd7, 3'd0, '0);
		queue_op(MODE_CURRENT, 3'd7, 3'd0, '0);
		queue_op(MODE_ADD, 3'd7, 3'd0, 32'h0000_0000);
		queue_op(MODE_INSERT, 3'd7, 3'd0, 32'hFFFF_FFFF);
		queue_op(MODE_APPEND, 3'd7, 3'd0, 32'h8000_0001);
		queue_op(MODE_PREV, 3'd7, 3'd0, '0);
		queue_op(MODE_PREV, 3'd7, 3'd0, '0);
		queue_op(MODE_CONCAT, 3'd7, 3'd7, '0);
		queue_op(MODE_CONCAT, 3'd7, 3'd6, '0);
		queue_op(MODE_CONCAT, 3'd7, 3'd6, '0);
		queue_op(MODE_REMOVE, 3'd7, 3'd0, '0);
		queue_op(MODE_TRIM, 3'd7, 3'd0, '0);
		queue_op(MODE_FREE, 3'd5, 3'd0, '0);
		queue_op(MODE_FREE, 3'd7, 3'd0, '0);
		// random part, with a burst that drains the node pool midway
		for (int i = 0; i < 10; i++) random_op();
		l = pick_list();
		if (!m_head[l].alloc) begin
			queue_op(MODE_CREATE, '0, '0, '0);
			l = pick_list();
		end
		for (int i = 0; i < NODE_COUNT + 2; i++)
			queue_op(4'($urandom_range(MODE_PREPEND, MODE_ADD)), l, 3'($urandom), $urandom);
		queue_op(MODE_FIRST, l, '0, '0);
		queue_op(MODE_NEXT, l, '0, '0);
		queue_op(MODE_LAST, l, '0, '0);
		queue_op(MODE_NEXT, l, '0, '0);
		queue_op(MODE_FREE, l, '0, '0);
		for (int i = 0; i < 10; i++) random_op();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// drain, then allow the longest operation to finish
		while (op_q.size() > 0 || start || beat_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && beat_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/pcle_pkg.sv
rtl/pcle_ctrl.sv
rtl/pcle_datapath.sv
rtl/pooled_cursor_list_engine.sv
test/pooled_cursor_list_engine_tb.sv
